// ----- src/mbe_pkg.sv -----
package mbe_pkg;

   localparam int COUNT_W = 16;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-3:0] CSR_MAX_ITERATIONS = 1'b0;
   localparam logic [COUNT_W-1:0] MAX_ITERATIONS_RESET = 16'd2000;

   typedef struct packed {
      logic signed [31:0] c_real;
      logic signed [31:0] c_imag;
   } req_payload_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iteration_count;
      logic inside_set;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic update;
      logic finish;
   } dp_cmd_type;

   typedef struct packed {
      logic at_limit;
      logic escape;
   } dp_status_type;

endpackage

// ----- src/mbe_csr.sv -----
module mbe_csr (
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mbe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbe_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready,
   output logic [mbe_pkg::COUNT_W-1:0] max_iterations
);

   logic [mbe_pkg::COUNT_W-1:0] max_iter_ff;
   logic [mbe_pkg::COUNT_W-1:0] max_iter_in;
   logic hit;

   assign pready = 1'b1;
   assign hit = (paddr[mbe_pkg::CSR_ADDR_W-1:2] == mbe_pkg::CSR_MAX_ITERATIONS);

   always_comb begin
      max_iter_in = max_iter_ff;
      if (psel && penable && pwrite && hit) begin
         max_iter_in = pwdata[mbe_pkg::COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= mbe_pkg::MAX_ITERATIONS_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (hit) begin
         prdata = {{(mbe_pkg::CSR_DATA_W-mbe_pkg::COUNT_W){1'b0}}, max_iter_ff};
      end
   end

   assign max_iterations = max_iter_ff;

endmodule

// ----- src/mbe_datapath.sv -----
module mbe_datapath #(
   parameter int FRAC_BITS = 28,
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  mbe_pkg::dp_cmd_type cmd,
   output mbe_pkg::dp_status_type status,
   input  mbe_pkg::req_payload_type req_data,
   input  logic [mbe_pkg::COUNT_W-1:0] max_iterations,
   output mbe_pkg::rsp_payload_type rsp_data
);

   localparam int IN_W = (WORD_BITS > 32) ? WORD_BITS : 32;
   localparam int PROD_W = 2 * WORD_BITS;
   localparam int SUM_W = (2 * WORD_BITS + 1 > 2 * FRAC_BITS + 3) ?
                          2 * WORD_BITS + 1 : 2 * FRAC_BITS + 3;
   localparam int DIFF_W = (2 * WORD_BITS + 1 > FRAC_BITS + WORD_BITS) ?
                           2 * WORD_BITS + 1 : FRAC_BITS + WORD_BITS;
   localparam int XP_W = (PROD_W > FRAC_BITS - 1 + WORD_BITS) ?
                         PROD_W : FRAC_BITS - 1 + WORD_BITS;
   localparam logic [SUM_W-1:0] THRESH = {{(SUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

   logic signed [IN_W-1:0] cr_ext;
   logic signed [IN_W-1:0] ci_ext;

   logic signed [WORD_BITS-1:0] cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [WORD_BITS-1:0] cr_in, ci_in, zr_in, zi_in;
   logic signed [PROD_W-1:0] rr_ff, ii_ff, ri_ff;
   logic signed [PROD_W-1:0] rr_in, ii_in, ri_in;
   logic [mbe_pkg::COUNT_W-1:0] count_ff, count_in;
   mbe_pkg::rsp_payload_type rsp_ff, rsp_in;

   logic [SUM_W-1:0] mag;
   logic signed [DIFF_W-1:0] diff;
   logic signed [XP_W-1:0] ri_wide;
   logic signed [WORD_BITS-1:0] zr_next, zi_next;

   assign cr_ext = IN_W'(req_data.c_real);
   assign ci_ext = IN_W'(req_data.c_imag);

   assign mag = SUM_W'($unsigned(rr_ff)) + SUM_W'($unsigned(ii_ff));
   assign diff = DIFF_W'(rr_ff) - DIFF_W'(ii_ff);
   assign ri_wide = XP_W'(ri_ff);
   assign zr_next = diff[FRAC_BITS +: WORD_BITS] + cr_ff;
   assign zi_next = ri_wide[FRAC_BITS-1 +: WORD_BITS] + ci_ff;

   assign status.at_limit = (count_ff >= max_iterations);
   assign status.escape = (mag > THRESH);

   always_comb begin
      cr_in = cr_ff;
      ci_in = ci_ff;
      zr_in = zr_ff;
      zi_in = zi_ff;
      count_in = count_ff;
      rr_in = rr_ff;
      ii_in = ii_ff;
      ri_in = ri_ff;
      rsp_in = rsp_ff;
      if (cmd.load) begin
         cr_in = cr_ext[WORD_BITS-1:0];
         ci_in = ci_ext[WORD_BITS-1:0];
         zr_in = '0;
         zi_in = '0;
         count_in = '0;
      end
      if (cmd.mul) begin
         rr_in = zr_ff * zr_ff;
         ii_in = zi_ff * zi_ff;
         ri_in = zr_ff * zi_ff;
      end
      if (cmd.update) begin
         zr_in = zr_next;
         zi_in = zi_next;
         count_in = count_ff + 1'b1;
      end
      if (cmd.finish) begin
         rsp_in.iteration_count = count_ff;
         rsp_in.inside_set = (count_ff == max_iterations);
      end
   end

   always_ff @(posedge clock) begin
      cr_ff <= cr_in;
      ci_ff <= ci_in;
      zr_ff <= zr_in;
      zi_ff <= zi_in;
      count_ff <= count_in;
      rr_ff <= rr_in;
      ii_ff <= ii_in;
      ri_ff <= ri_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ----- src/mbe_ctrl.sv -----
module mbe_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   output logic rsp_valid,
   output mbe_pkg::dp_cmd_type cmd,
   input  mbe_pkg::dp_status_type status
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOP = 2'd1;
   localparam logic [1:0] S_TEST = 2'd2;

   logic [1:0] state_ff, state_in;
   logic valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (status.at_limit) begin
               cmd.finish = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.mul = 1'b1;
               state_in = S_TEST;
            end
         end
         S_TEST: begin
            if (status.escape) begin
               cmd.finish = 1'b1;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               cmd.update = 1'b1;
               state_in = S_LOOP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

endmodule

// ----- src/mandelbrot_escape_time_core.sv -----
// Mandelbrot escape-time core.
// Command channel: present c on req_data and raise start; the point is taken
// at a clock edge where start is high and busy is low. busy stays high while
// the point is iterated.
// Result channel: rsp_valid is high for exactly one cycle with rsp_data
// (iteration count and inside-set flag); the receiver cannot stall it, so it
// must take the transfer in that cycle.
// Configuration: APB-style port, max_iterations at byte address 0, written
// while the core is idle; pready is always high.
// Iteration: each pass forms the three products in state S_LOOP, then
// tests |z|^2 and updates z in state S_TEST. busy drops in the cycle the
// result is shown, so the next point may be taken then.
// Reset: synchronous, clears the controller and sets max_iterations to 2000.
module mandelbrot_escape_time_core #(
   parameter int FRAC_BITS = 28,
   parameter int WORD_BITS = 32
) (
   input  logic clock,
   input  logic reset,
   input  logic start,
   output logic busy,
   input  mbe_pkg::req_payload_type req_data,
   output logic rsp_valid,
   output mbe_pkg::rsp_payload_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [mbe_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mbe_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mbe_pkg::CSR_DATA_W-1:0] prdata,
   output logic pready
);

   logic [mbe_pkg::COUNT_W-1:0] max_iterations;
   mbe_pkg::dp_cmd_type cmd;
   mbe_pkg::dp_status_type status;

   mbe_csr u_csr (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .max_iterations(max_iterations)
   );

   mbe_datapath #(
      .FRAC_BITS(FRAC_BITS),
      .WORD_BITS(WORD_BITS)
   ) u_datapath (
      .clock(clock),
      .cmd(cmd),
      .status(status),
      .req_data(req_data),
      .max_iterations(max_iterations),
      .rsp_data(rsp_data)
   );

   mbe_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .rsp_valid(rsp_valid),
      .cmd(cmd),
      .status(status)
   );

endmodule
